>>> rtl/core/rnc_pkg.sv
`default_nettype none
package rnc_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_LEAF  = 2'd0,
    CMD_LOAD_POINT = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_UNUSED     = 2'd3
  } cmd_t;

  localparam logic [0:0] CFG_RADIUS     = 1'b0;
  localparam logic [0:0] CFG_LEAF_COUNT = 1'b1;

  localparam int MAX_LEAVES = 256;
  localparam int MAX_POINTS = 1024;

  localparam int RADIUS_W = 35;
  localparam int LCOUNT_W = 9;
  localparam int RANGE_W  = 11;
  localparam int ORDER_W  = 10;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAF_RD,
    ST_LEAF_WAIT,
    ST_LEAF_DX,
    ST_LEAF_DY,
    ST_LEAF_CMP,
    ST_ORD_RD,
    ST_ORD_WAIT,
    ST_PT_WAIT,
    ST_PT_DX,
    ST_PT_DY,
    ST_PT_CMP,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/rnc_sqacc.sv
`default_nettype none
// Shared squared-distance unit: one difference squared per cycle while en is high, accumulated.
module rnc_sqacc
  import rnc_pkg::*;
#(
  parameter int CW = 16
) (
  input  wire logic                  clk,
  input  wire logic                  clear,
  input  wire logic                  en,
  input  wire logic signed [CW-1:0]  a,
  input  wire logic signed [CW-1:0]  b,
  output logic [2*CW+2:0]            acc
);
  logic signed [CW:0] diff;
  logic [CW:0]        mag;
  logic [2*CW+1:0]    sq;

  always_comb begin
    diff = {a[CW-1], a} - {b[CW-1], b};
    mag  = diff[CW] ? (~diff + 1'b1) : diff;
    sq   = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc + {1'b0, sq};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/radius_neighbor_count_core.sv
`default_nettype none
// Loads are taken while idle, one beat per cycle. A query walks each leaf up to
// the leaf count: a registered leaf read, then the box distance from the single
// squared-distance unit; for leaves within the radius, each order slot is read,
// then its point, then its distance is compared. The block is ready again in
// the cycle the count appears, or holds until a still-waiting count is taken.
// Synchronous reset clears control and the config registers; tables stay
// undefined until loaded.
module radius_neighbor_count_core
  import rnc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [34:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // command[1:0], entry_index, box_x_low, box_y_low, box_x_high, box_y_high,
  // range_begin, range_end, order_value, coord_x, coord_y, zero pad
  input  wire logic [8*((2+10+4*COORD_BITS+22+10+2*COORD_BITS+7)/8)-1:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // neighbor_count[10:0], zero pad
  output logic [15:0]       m_tdata
);
  localparam int LW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = COORD_BITS;
  localparam int DW = 2*CW+3;
  localparam int CMP_W = (DW > RADIUS_W) ? DW : RADIUS_W;
  localparam int O_IDX = 2;
  localparam int O_BXL = O_IDX + INDEX_W;
  localparam int O_BYL = O_BXL + CW;
  localparam int O_BXH = O_BYL + CW;
  localparam int O_BYH = O_BXH + CW;
  localparam int O_RB  = O_BYH + CW;
  localparam int O_RE  = O_RB + RANGE_W;
  localparam int O_OV  = O_RE + RANGE_W;
  localparam int O_CX  = O_OV + ORDER_W;
  localparam int O_CY  = O_CX + CW;

  cmd_t                   in_cmd;
  logic [INDEX_W-1:0]     in_idx;
  logic signed [CW-1:0]   in_bxl, in_byl, in_bxh, in_byh, in_cx, in_cy;
  logic [RANGE_W-1:0]     in_rb, in_re;
  logic [ORDER_W-1:0]     in_ov;

  assign in_cmd = cmd_t'(s_tdata[1:0]);
  assign in_idx = s_tdata[O_IDX +: INDEX_W];
  assign in_bxl = s_tdata[O_BXL +: CW];
  assign in_byl = s_tdata[O_BYL +: CW];
  assign in_bxh = s_tdata[O_BXH +: CW];
  assign in_byh = s_tdata[O_BYH +: CW];
  assign in_rb  = s_tdata[O_RB +: RANGE_W];
  assign in_re  = s_tdata[O_RE +: RANGE_W];
  assign in_ov  = s_tdata[O_OV +: ORDER_W];
  assign in_cx  = s_tdata[O_CX +: CW];
  assign in_cy  = s_tdata[O_CY +: CW];

  logic [RADIUS_W-1:0] radius_squared;
  logic [LCOUNT_W-1:0] leaf_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_squared <= '0;
      leaf_count     <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RADIUS) begin
        radius_squared <= cfg_data;
      end else begin
        leaf_count <= cfg_data[LCOUNT_W-1:0];
      end
    end
  end

  // Leaf box memory: corners and range packed in one word.
  localparam int LEAF_W = 4*CW + 2*RANGE_W;
  logic [LEAF_W-1:0] leaf_mem [MAX_LEAVES];
  logic [ORDER_W-1:0] order_mem [MAX_POINTS];
  logic [2*CW-1:0]    point_mem [MAX_POINTS];

  logic [LEAF_W-1:0]  leaf_rd;
  logic [ORDER_W-1:0] order_rd;
  logic [2*CW-1:0]    point_rd;

  logic accept;
  assign accept = s_tvalid && s_tready;

  // The output register is free when empty or being emptied this cycle.
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  state_t state, state_next;
  logic [LCOUNT_W-1:0] li;
  logic [RANGE_W-1:0]  slot, slot_end;
  logic signed [CW-1:0] qx, qy, bx, by;
  logic [COUNT_W-1:0] hits;
  logic [COUNT_W-1:0] out_count;

  logic [RANGE_W:0] ext_slot;
  logic [LCOUNT_W:0] walk_lim;
  assign ext_slot = {1'b0, slot};
  assign walk_lim = (leaf_count > LCOUNT_W'(MAX_LEAVES)) ? (LCOUNT_W+1)'(MAX_LEAVES)
                                                         : {1'b0, leaf_count};

  always_ff @(posedge clk) begin
    if (accept && in_cmd == CMD_LOAD_LEAF && {1'b0, in_idx} < (INDEX_W+1)'(MAX_LEAVES)) begin
      leaf_mem[in_idx[LW-1:0]] <= {in_re, in_rb, in_byh, in_bxh, in_byl, in_bxl};
    end
    if (accept && in_cmd == CMD_LOAD_POINT && {1'b0, in_idx} < (INDEX_W+1)'(MAX_POINTS)) begin
      order_mem[in_idx[PW-1:0]] <= in_ov;
      point_mem[in_idx[PW-1:0]] <= {in_cy, in_cx};
    end
    leaf_rd  <= leaf_mem[li[LW-1:0]];
    order_rd <= order_mem[slot[PW-1:0]];
    point_rd <= point_mem[order_rd[PW-1:0]];
  end

  // Shared squared-distance unit.
  logic            sq_clear, sq_en;
  logic signed [CW-1:0] sq_a, sq_b;
  logic [DW-1:0]   sq_acc;

  rnc_sqacc #(.CW(CW)) u_sq (
    .clk(clk), .clear(sq_clear), .en(sq_en), .a(sq_a), .b(sq_b), .acc(sq_acc)
  );

  logic [CMP_W-1:0] dist_cmp, radius_cmp;
  assign dist_cmp   = CMP_W'(sq_acc);
  assign radius_cmp = CMP_W'(radius_squared);

  // Box test result is valid in ST_ORD_RD, which follows ST_LEAF_CMP.
  logic box_far;
  assign box_far = dist_cmp > radius_cmp;
  logic first_ord;
  logic skip_leaf;
  assign skip_leaf = first_ord && box_far;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    sq_clear   = 1'b0;
    sq_en      = 1'b0;
    sq_a       = qx;
    sq_b       = bx;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept && in_cmd == CMD_QUERY) state_next = ST_LEAF_RD;
      end
      ST_LEAF_RD: begin
        if ({1'b0, li} >= walk_lim) state_next = ST_DONE;
        else state_next = ST_LEAF_WAIT;
      end
      ST_LEAF_WAIT: state_next = ST_LEAF_DX;
      ST_LEAF_DX: begin
        sq_clear = 1'b1;
        state_next = ST_LEAF_DY;
      end
      ST_LEAF_DY: begin
        sq_en = 1'b1;
        state_next = ST_LEAF_CMP;
      end
      ST_LEAF_CMP: begin
        sq_en = 1'b1;
        sq_a  = qy;
        sq_b  = by;
        state_next = ST_ORD_RD;
      end
      ST_ORD_RD: begin
        // First pass after the box test decides skip or walk.
        if (slot >= slot_end || ext_slot >= (RANGE_W+1)'(MAX_POINTS) || skip_leaf) begin
          state_next = ST_LEAF_RD;
        end else begin
          state_next = ST_ORD_WAIT;
        end
      end
      ST_ORD_WAIT: state_next = ST_PT_WAIT;
      ST_PT_WAIT: begin
        sq_clear = 1'b1;
        state_next = ST_PT_DX;
      end
      ST_PT_DX: begin
        sq_en = 1'b1;
        sq_a  = point_rd[CW-1:0];
        sq_b  = qx;
        state_next = ST_PT_DY;
      end
      ST_PT_DY: begin
        sq_en = 1'b1;
        sq_a  = point_rd[2*CW-1:CW];
        sq_b  = qy;
        state_next = ST_PT_CMP;
      end
      ST_PT_CMP: state_next = ST_ORD_RD;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  logic order_ok;
  assign order_ok = ({1'b0, order_rd} < (ORDER_W+1)'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == ST_DONE && out_free) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        qx   <= in_cx;
        qy   <= in_cy;
        li   <= '0;
        hits <= '0;
      end
      ST_LEAF_DX: begin
        slot     <= leaf_rd[4*CW +: RANGE_W];
        slot_end <= leaf_rd[4*CW+RANGE_W +: RANGE_W];
        bx <= (qx < $signed(leaf_rd[0 +: CW])) ? $signed(leaf_rd[0 +: CW]) :
              (qx > $signed(leaf_rd[2*CW +: CW])) ? $signed(leaf_rd[2*CW +: CW]) : qx;
        by <= (qy < $signed(leaf_rd[CW +: CW])) ? $signed(leaf_rd[CW +: CW]) :
              (qy > $signed(leaf_rd[3*CW +: CW])) ? $signed(leaf_rd[3*CW +: CW]) : qy;
      end
      ST_ORD_RD: begin
        if (skip_leaf) begin
          slot_end <= slot;
        end
        if (slot >= slot_end || ext_slot >= (RANGE_W+1)'(MAX_POINTS) || skip_leaf) begin
          li <= li + 1'b1;
        end
      end
      ST_PT_CMP: begin
        if (order_ok && dist_cmp <= radius_cmp && hits != COUNT_MAX) hits <= hits + 1'b1;
        slot <= slot + 1'b1;
      end
      ST_DONE: begin
        if (out_free) out_count <= hits;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) first_ord <= 1'b0;
    else first_ord <= (state == ST_LEAF_CMP);
  end

  assign m_tdata = {{(16-COUNT_W){1'b0}}, out_count};
endmodule
`default_nettype wire

>>> rtl/core/rnc_checker.sv
`default_nettype none
module rnc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [15:0] m_tdata
);
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({s_tready, m_tvalid})) else $error("handshake signal unknown");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:11] == 5'd0) else $error("pad bits set");
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("valid after reset");
endmodule

bind radius_neighbor_count_core rnc_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
